/* rtl/rtp_pkg.sv */
// Shared types and constants for the reciprocating trapezoid profile.
// No dependencies; used by every module of the block except rtp_div.
package rtp_pkg;

   // Width of the internal time and profile quantities (ta, tc, half, period).
   localparam int TW = 52;
   // Width of the signed one-way position offset.
   localparam int PW = 50;
   // Width used for the saturating output add.
   localparam int SW = 66;

   // Modulo pipeline: two remainder bits per stage over a 32 bit time word.
   localparam int MOD_BITS   = 2;
   localparam int MOD_STAGES = 32 / MOD_BITS;

   // Configuration register indexes.
   localparam int CSR_AW = 3;
   localparam logic [CSR_AW-1:0] REG_ORIGIN_X = 3'd0;
   localparam logic [CSR_AW-1:0] REG_ORIGIN_Y = 3'd1;
   localparam logic [CSR_AW-1:0] REG_ORIGIN_Z = 3'd2;
   localparam logic [CSR_AW-1:0] REG_AXIS     = 3'd3;
   localparam logic [CSR_AW-1:0] REG_STROKE   = 3'd4;
   localparam logic [CSR_AW-1:0] REG_CRUISE   = 3'd5;
   localparam logic [CSR_AW-1:0] REG_ACCEL    = 3'd6;

   // Axis codes.
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   // Reset values.
   localparam logic [30:0] STROKE_RST = 31'd6554;
   localparam logic [30:0] CRUISE_RST = 31'd6554;
   localparam logic [30:0] ACCEL_RST  = 31'd65536;

   typedef enum logic [3:0] {
      SU_MUL,
      SU_PICK,
      SU_SQRT,
      SU_DA_GO,
      SU_DA,
      SU_TC_GO,
      SU_TC,
      SU_TA_GO,
      SU_TA,
      SU_FIN,
      SU_DONE
   } su_state_type;

   typedef enum logic [1:0] {
      PH_ACCEL,
      PH_CRUISE,
      PH_DECEL
   } phase_type;

   // Profile constants derived from the configuration.
   typedef struct packed {
      logic [30:0]   vmax;
      logic [30:0]   accel;
      logic [30:0]   stroke;
      logic [30:0]   da;
      logic [30:0]   dc;
      logic [TW-1:0] ta;
      logic [TW-1:0] tac;
      logic [TW-1:0] half;
      logic [31:0]   per_lo;
      logic          per_zero;
      logic          per_big;
   } prof_type;

endpackage

/* rtl/rtp_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
// Depends on nothing; used by rtp_setup.
module rtp_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [32:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] q_ff, q_in;
   logic [33:0] rem_ff, rem_in;
   logic [32:0] dsr_ff, dsr_in;
   logic [33:0] rem_sh;
   logic        ge;

   always_comb begin
      rem_sh  = {rem_ff[32:0], q_ff[63]};
      ge      = rem_sh >= {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         q_in    = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? rem_sh - {1'b0, dsr_ff} : rem_sh;
         q_in   = {q_ff[62:0], ge};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

/* rtl/rtp_setup.sv */
// Profile setup sequencer: derives vmax, ta, tc, da, dc and period from config.
// Depends on rtp_pkg and rtp_div.
module rtp_setup (
   input  logic              clock,
   input  logic              reset,
   input  logic              restart,
   input  logic [30:0]       stroke,
   input  logic [30:0]       cruise,
   input  logic [30:0]       accel,
   output logic              busy,
   output rtp_pkg::prof_type prof
);

   localparam int TW = rtp_pkg::TW;

   rtp_pkg::su_state_type state_ff, state_in;

   logic [30:0]   a_eff, v_eff;
   logic [61:0]   vv_ff, al_ff;
   logic [30:0]   vmax_ff, da_ff, dc_ff;
   logic [TW-1:0] ta_ff, tc_ff;
   logic [61:0]   xs_ff;
   logic [33:0]   sq_rem_ff;
   logic [30:0]   root_ff;
   logic [4:0]    cnt_ff;
   logic [33:0]   sq_sh, sq_trial;
   logic          sq_ge;
   logic [31:0]   dc_c;
   logic [TW-1:0] half_c, tac_c, per_c;
   rtp_pkg::prof_type prof_ff;

   logic        div_start, div_done;
   logic [63:0] div_dvd, div_q;
   logic [32:0] div_dsr;

   assign a_eff    = (accel == '0) ? 31'd1 : accel;
   assign v_eff    = (cruise == '0) ? 31'd1 : cruise;
   assign sq_sh    = {sq_rem_ff[31:0], xs_ff[61:60]};
   assign sq_trial = {1'b0, root_ff, 2'b01};
   assign sq_ge    = sq_sh >= sq_trial;
   assign dc_c     = {1'b0, stroke} - {da_ff, 1'b0};
   assign half_c   = {ta_ff[TW-2:0], 1'b0} + tc_ff;
   assign tac_c    = ta_ff + tc_ff;
   assign per_c    = {half_c[TW-2:0], 1'b0};

   rtp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dsr),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rtp_pkg::SU_MUL;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      div_dvd   = {2'b0, vv_ff};
      div_dsr   = {1'b0, a_eff, 1'b0};
      case (state_ff)
         rtp_pkg::SU_MUL:  state_in = rtp_pkg::SU_PICK;
         rtp_pkg::SU_PICK: begin
            state_in = (vv_ff > al_ff) ? rtp_pkg::SU_SQRT : rtp_pkg::SU_DA_GO;
         end
         rtp_pkg::SU_SQRT: begin
            if (cnt_ff == 5'd30) state_in = rtp_pkg::SU_TA_GO;
         end
         rtp_pkg::SU_DA_GO: begin
            div_start = 1'b1;
            state_in  = rtp_pkg::SU_DA;
         end
         rtp_pkg::SU_DA: begin
            if (div_done) state_in = rtp_pkg::SU_TC_GO;
         end
         rtp_pkg::SU_TC_GO: begin
            div_start = 1'b1;
            div_dvd   = {17'b0, dc_c[30:0], 16'b0};
            div_dsr   = {2'b0, v_eff};
            state_in  = rtp_pkg::SU_TC;
         end
         rtp_pkg::SU_TC: begin
            if (div_done) state_in = rtp_pkg::SU_TA_GO;
         end
         rtp_pkg::SU_TA_GO: begin
            div_start = 1'b1;
            div_dvd   = {17'b0, vmax_ff, 16'b0};
            div_dsr   = {2'b0, a_eff};
            state_in  = rtp_pkg::SU_TA;
         end
         rtp_pkg::SU_TA: begin
            if (div_done) state_in = rtp_pkg::SU_FIN;
         end
         rtp_pkg::SU_FIN:  state_in = rtp_pkg::SU_DONE;
         rtp_pkg::SU_DONE: state_in = rtp_pkg::SU_DONE;
         default:          state_in = rtp_pkg::SU_MUL;
      endcase
      if (restart) state_in = rtp_pkg::SU_MUL;
   end

   // datapath registers, loaded per state
   always_ff @(posedge clock) begin
      case (state_ff)
         rtp_pkg::SU_MUL: begin
            vv_ff <= {31'b0, v_eff} * {31'b0, v_eff};
            al_ff <= {31'b0, a_eff} * {31'b0, stroke};
         end
         rtp_pkg::SU_PICK: begin
            // triangular: peak sqrt(A*L), no cruise; DA/TC states override
            da_ff     <= {1'b0, stroke[30:1]};
            dc_ff     <= '0;
            tc_ff     <= '0;
            xs_ff     <= al_ff;
            sq_rem_ff <= '0;
            root_ff   <= '0;
            cnt_ff    <= '0;
            vmax_ff   <= v_eff;
         end
         rtp_pkg::SU_SQRT: begin
            sq_rem_ff <= sq_ge ? sq_sh - sq_trial : sq_sh;
            root_ff   <= {root_ff[29:0], sq_ge};
            xs_ff     <= {xs_ff[59:0], 2'b00};
            cnt_ff    <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd30) vmax_ff <= {root_ff[29:0], sq_ge};
         end
         rtp_pkg::SU_DA: begin
            if (div_done) da_ff <= div_q[30:0];
         end
         rtp_pkg::SU_TC_GO: dc_ff <= dc_c[30:0];
         rtp_pkg::SU_TC: begin
            if (div_done) tc_ff <= div_q[TW-1:0];
         end
         rtp_pkg::SU_TA: begin
            if (div_done) ta_ff <= div_q[TW-1:0];
         end
         rtp_pkg::SU_FIN: begin
            prof_ff.vmax     <= vmax_ff;
            prof_ff.accel    <= a_eff;
            prof_ff.stroke   <= stroke;
            prof_ff.da       <= da_ff;
            prof_ff.dc       <= dc_ff;
            prof_ff.ta       <= ta_ff;
            prof_ff.tac      <= tac_c;
            prof_ff.half     <= half_c;
            prof_ff.per_lo   <= per_c[31:0];
            prof_ff.per_zero <= per_c == '0;
            prof_ff.per_big  <= |per_c[TW-1:32];
         end
         default: ;
      endcase
   end

   assign busy = state_ff != rtp_pkg::SU_DONE;
   assign prof = prof_ff;

endmodule

/* rtl/rtp_mod.sv */
// Pipelined time modulo: t mod period, two remainder bits per stage.
// Depends on rtp_pkg.
module rtp_mod (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [31:0] in_time,
   output logic        in_stall,
   input  logic [31:0] divisor,
   output logic        out_valid,
   output logic [31:0] out_time,
   output logic [31:0] out_rem,
   input  logic        out_stall
);

   localparam int N = rtp_pkg::MOD_STAGES;
   localparam int B = rtp_pkg::MOD_BITS;

   logic [N-1:0]       valid_ff, valid_in, adv;
   logic [N-1:0][31:0] time_ff, time_in, rem_ff, rem_in;
   // stage inputs: the port for stage 0, the previous stage otherwise
   logic [N-1:0]       src_valid;
   logic [N-1:0][31:0] src_time, src_rem;

   assign src_valid = {valid_ff[N-2:0], in_valid};
   assign src_time  = {time_ff[N-2:0], in_time};
   assign src_rem   = {rem_ff[N-2:0], 32'b0};

   always_comb begin
      logic [31:0] r;
      logic [32:0] sh;
      logic [31:0] t;
      // bubble-collapsing advance chain, from the output back
      adv[N-1] = !valid_ff[N-1] || !out_stall;
      for (int k = N - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
      for (int k = 0; k < N; k++) begin
         valid_in[k] = src_valid[k];
         t           = src_time[k];
         r           = src_rem[k];
         for (int j = 0; j < B; j++) begin
            sh = {r, t[31 - B*k - j]};
            r  = (sh >= {1'b0, divisor}) ? 32'(sh - {1'b0, divisor}) : sh[31:0];
         end
         time_in[k] = t;
         rem_in[k]  = r;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < N; k++) begin
            if (adv[k]) valid_ff[k] <= valid_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < N; k++) begin
         if (adv[k]) begin
            time_ff[k] <= time_in[k];
            rem_ff[k]  <= rem_in[k];
         end
      end
   end

   assign in_stall  = !adv[0];
   assign out_valid = valid_ff[N-1];
   assign out_time  = time_ff[N-1];
   assign out_rem   = rem_ff[N-1];

endmodule

/* rtl/rtp_eval.sv */
// Profile evaluation pipeline: half select, phase, products, position, output.
// Depends on rtp_pkg.
module rtp_eval #(
   parameter int DATA_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  rtp_pkg::prof_type prof,
   input  logic [31:0]       origin_x,
   input  logic [31:0]       origin_y,
   input  logic [31:0]       origin_z,
   input  logic [1:0]        move_axis,
   input  logic              in_valid,
   input  logic [31:0]       in_time,
   input  logic [31:0]       in_rem,
   output logic              in_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [31:0]       rsp_pos_x,
   output logic [31:0]       rsp_pos_y,
   output logic [31:0]       rsp_pos_z,
   output logic [31:0]       rsp_vel_x,
   output logic [31:0]       rsp_vel_y,
   output logic [31:0]       rsp_vel_z,
   output logic              rsp_returning
);

   localparam int TW = rtp_pkg::TW;
   localparam int PW = rtp_pkg::PW;
   localparam int SW = rtp_pkg::SW;
   localparam logic signed [SW-1:0] SAT_HI =
      $signed(({{(SW-1){1'b0}}, 1'b1} << (DATA_WIDTH - 1)) - {{(SW-1){1'b0}}, 1'b1});
   localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - {{(SW-1){1'b0}}, 1'b1};

   logic [7:1] v_ff, adv;

   // stage 1: half select
   logic [31:0] tm_1_ff, tm_1_in;
   logic        ret_1_ff, ret_1_in;
   // stage 2: phase and dt
   logic [31:0]        dt_2_ff, dt_2_in;
   rtp_pkg::phase_type ph_2_ff, ph_2_in;
   logic               ret_2_ff;
   // stage 3: first products
   logic [62:0]        pa_3_ff, pv_3_ff;
   logic [31:0]        dt_3_ff;
   rtp_pkg::phase_type ph_3_ff;
   logic               ret_3_ff;
   // stage 4: speed
   logic [30:0]        m_4_ff, m_4_in, mag_4_ff, mag_4_in;
   logic [46:0]        pv_4_ff;
   logic [31:0]        dt_4_ff;
   rtp_pkg::phase_type ph_4_ff;
   logic               ret_4_ff;
   // stage 5: second product
   logic [62:0]        p2_5_ff;
   logic [46:0]        pv_5_ff;
   logic [30:0]        mag_5_ff;
   rtp_pkg::phase_type ph_5_ff;
   logic               ret_5_ff;
   // stage 6: position offset
   logic signed [PW-1:0] p_6_ff, p_6_in;
   logic signed [31:0]   vel_6_ff, vel_6_in;
   logic                 ret_6_ff;
   // stage 7: output word
   logic [31:0] pos_x_in, pos_y_in, pos_z_in, vel_x_in, vel_y_in, vel_z_in;
   logic [31:0] pos_x_ff, pos_y_ff, pos_z_ff, vel_x_ff, vel_y_ff, vel_z_ff;
   logic        ret_7_ff;

   always_comb begin
      adv[7] = !v_ff[7] || !rsp_stall;
      for (int k = 6; k >= 1; k--) adv[k] = !v_ff[k] || adv[k+1];
   end

   // stage 1
   always_comb begin
      logic [31:0] tm;
      tm = prof.per_zero ? '0 : (prof.per_big ? in_time : in_rem);
      ret_1_in = !prof.per_zero && ({{(TW-32){1'b0}}, tm} >= prof.half);
      tm_1_in  = ret_1_in ? tm - prof.half[31:0] : tm;
   end

   // stage 2
   always_comb begin
      logic [TW-1:0] tx;
      tx = {{(TW-32){1'b0}}, tm_1_ff};
      if (tx < prof.ta) begin
         ph_2_in = rtp_pkg::PH_ACCEL;
         dt_2_in = tm_1_ff;
      end else if (tx < prof.tac) begin
         ph_2_in = rtp_pkg::PH_CRUISE;
         dt_2_in = tm_1_ff - prof.ta[31:0];
      end else begin
         ph_2_in = rtp_pkg::PH_DECEL;
         dt_2_in = tm_1_ff - prof.tac[31:0];
      end
   end

   // stage 4: speed lost in decel is clamped at vmax
   always_comb begin
      logic [46:0] s;
      logic [30:0] sc;
      s  = pa_3_ff[62:16];
      sc = (s < {16'b0, prof.vmax}) ? s[30:0] : prof.vmax;
      case (ph_3_ff)
         rtp_pkg::PH_ACCEL: begin
            m_4_in   = s[30:0];
            mag_4_in = s[30:0];
         end
         rtp_pkg::PH_CRUISE: begin
            m_4_in   = sc;
            mag_4_in = prof.vmax;
         end
         default: begin
            m_4_in   = sc;
            mag_4_in = prof.vmax - sc;
         end
      endcase
   end

   // stage 6
   always_comb begin
      logic signed [PW-1:0] h2, pv, da, dc, len, p;
      h2  = $signed({{(PW-46){1'b0}}, p2_5_ff[62:17]});
      pv  = $signed({{(PW-47){1'b0}}, pv_5_ff});
      da  = $signed({{(PW-31){1'b0}}, prof.da});
      dc  = $signed({{(PW-31){1'b0}}, prof.dc});
      len = $signed({{(PW-31){1'b0}}, prof.stroke});
      case (ph_5_ff)
         rtp_pkg::PH_ACCEL:  p = h2;
         rtp_pkg::PH_CRUISE: p = da + pv;
         default: begin
            p = da + dc + pv - h2;
            if (p > len) p = len;
         end
      endcase
      if (ret_5_ff) begin
         p_6_in   = len - p;
         vel_6_in = -$signed({1'b0, mag_5_ff});
      end else begin
         p_6_in   = p;
         vel_6_in = $signed({1'b0, mag_5_ff});
      end
   end

   // stage 7: origin add with saturation, axis select
   always_comb begin
      logic [31:0]          org;
      logic signed [SW-1:0] sum;
      logic [31:0]          pos;
      case (move_axis)
         rtp_pkg::AXIS_X: org = origin_x;
         rtp_pkg::AXIS_Y: org = origin_y;
         default:         org = origin_z;
      endcase
      sum = $signed({{(SW-32){org[31]}}, org}) + $signed({{(SW-PW){p_6_ff[PW-1]}}, p_6_ff});
      if (sum > SAT_HI)      pos = SAT_HI[31:0];
      else if (sum < SAT_LO) pos = SAT_LO[31:0];
      else                   pos = sum[31:0];
      pos_x_in = origin_x;
      pos_y_in = origin_y;
      pos_z_in = origin_z;
      vel_x_in = '0;
      vel_y_in = '0;
      vel_z_in = '0;
      case (move_axis)
         rtp_pkg::AXIS_X: begin
            pos_x_in = pos;
            vel_x_in = vel_6_ff;
         end
         rtp_pkg::AXIS_Y: begin
            pos_y_in = pos;
            vel_y_in = vel_6_ff;
         end
         rtp_pkg::AXIS_Z: begin
            pos_z_in = pos;
            vel_z_in = vel_6_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (adv[1]) v_ff[1] <= in_valid;
         for (int k = 2; k <= 7; k++) begin
            if (adv[k]) v_ff[k] <= v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         tm_1_ff  <= tm_1_in;
         ret_1_ff <= ret_1_in;
      end
      if (adv[2]) begin
         dt_2_ff  <= dt_2_in;
         ph_2_ff  <= ph_2_in;
         ret_2_ff <= ret_1_ff;
      end
      if (adv[3]) begin
         pa_3_ff  <= {32'b0, prof.accel} * {31'b0, dt_2_ff};
         pv_3_ff  <= {32'b0, prof.vmax} * {31'b0, dt_2_ff};
         dt_3_ff  <= dt_2_ff;
         ph_3_ff  <= ph_2_ff;
         ret_3_ff <= ret_2_ff;
      end
      if (adv[4]) begin
         m_4_ff   <= m_4_in;
         mag_4_ff <= mag_4_in;
         pv_4_ff  <= pv_3_ff[62:16];
         dt_4_ff  <= dt_3_ff;
         ph_4_ff  <= ph_3_ff;
         ret_4_ff <= ret_3_ff;
      end
      if (adv[5]) begin
         p2_5_ff  <= {32'b0, m_4_ff} * {31'b0, dt_4_ff};
         pv_5_ff  <= pv_4_ff;
         mag_5_ff <= mag_4_ff;
         ph_5_ff  <= ph_4_ff;
         ret_5_ff <= ret_4_ff;
      end
      if (adv[6]) begin
         p_6_ff   <= p_6_in;
         vel_6_ff <= vel_6_in;
         ret_6_ff <= ret_5_ff;
      end
      if (adv[7]) begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         pos_z_ff <= pos_z_in;
         vel_x_ff <= vel_x_in;
         vel_y_ff <= vel_y_in;
         vel_z_ff <= vel_z_in;
         ret_7_ff <= ret_6_ff;
      end
   end

   assign in_stall      = !adv[1];
   assign rsp_valid     = v_ff[7];
   assign rsp_pos_x     = pos_x_ff;
   assign rsp_pos_y     = pos_y_ff;
   assign rsp_pos_z     = pos_z_ff;
   assign rsp_vel_x     = vel_x_ff;
   assign rsp_vel_y     = vel_y_ff;
   assign rsp_vel_z     = vel_z_ff;
   assign rsp_returning = ret_7_ff;

endmodule

/* rtl/reciprocating_trapezoid_profile.sv */
// Top level of the reciprocating trapezoid profile generator.
// Depends on rtp_pkg, rtp_setup, rtp_mod and rtp_eval.
//
// Usage:
//  - req_ channel carries one word per time sample (req_time_now, Q16.16 s).
//  - rsp_ channel returns one word per sample: position and velocity on x/y/z
//    (Q16.16) and the returning flag. Words leave in the order they entered.
//  - csr_ port writes the origin, axis, stroke, cruise speed and acceleration.
//  - The pipeline has 16 modulo stages (two remainder bits each) and
//    7 evaluation stages; the last stage is the rsp_ output register.
//  - Throughput is one word per cycle while req_stall is low; the pipeline
//    closes bubbles; a stalled output word blocks intake only in a full pipe.
//  - After reset and after every csr write the setup sequencer recomputes the
//    profile (products, a 31 step square root and up to three divisions),
//    during which req_stall is high.
//  - When rsp_stall is high the output word holds; upstream stages keep
//    filling until the pipe is full, then req_stall rises.
//  - Reset is synchronous, clears all valid bits and resets the csr registers.
module reciprocating_trapezoid_profile #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [rtp_pkg::CSR_AW-1:0] csr_index,
   input  logic [31:0]                csr_wdata,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [31:0]                req_time_now,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [31:0]                rsp_pos_x,
   output logic [31:0]                rsp_pos_y,
   output logic [31:0]                rsp_pos_z,
   output logic [31:0]                rsp_vel_x,
   output logic [31:0]                rsp_vel_y,
   output logic [31:0]                rsp_vel_z,
   output logic                       rsp_returning
);

   logic [31:0] origin_x_ff, origin_y_ff, origin_z_ff;
   logic [1:0]  axis_ff;
   logic [30:0] stroke_ff, cruise_ff, accel_ff;

   logic              setup_busy;
   rtp_pkg::prof_type prof;

   logic        mod_in_valid, mod_in_stall;
   logic        mod_out_valid, eval_in_stall;
   logic [31:0] mod_out_time, mod_out_rem;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         origin_z_ff <= '0;
         axis_ff     <= rtp_pkg::AXIS_X;
         stroke_ff   <= rtp_pkg::STROKE_RST;
         cruise_ff   <= rtp_pkg::CRUISE_RST;
         accel_ff    <= rtp_pkg::ACCEL_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            rtp_pkg::REG_ORIGIN_X: origin_x_ff <= csr_wdata;
            rtp_pkg::REG_ORIGIN_Y: origin_y_ff <= csr_wdata;
            rtp_pkg::REG_ORIGIN_Z: origin_z_ff <= csr_wdata;
            rtp_pkg::REG_AXIS:     axis_ff     <= csr_wdata[1:0];
            rtp_pkg::REG_STROKE:   stroke_ff   <= csr_wdata[30:0];
            rtp_pkg::REG_CRUISE:   cruise_ff   <= csr_wdata[30:0];
            rtp_pkg::REG_ACCEL:    accel_ff    <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   // profile constants; any write restarts the pass
   rtp_setup u_setup (
      .clock   (clock),
      .reset   (reset),
      .restart (csr_wr_en),
      .stroke  (stroke_ff),
      .cruise  (cruise_ff),
      .accel   (accel_ff),
      .busy    (setup_busy),
      .prof    (prof)
   );

   // hold intake while the profile is being rebuilt
   assign mod_in_valid = req_valid && !setup_busy && !csr_wr_en;
   assign req_stall    = setup_busy || csr_wr_en || mod_in_stall;

   // time wrap into one round trip
   rtp_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mod_in_valid),
      .in_time   (req_time_now),
      .in_stall  (mod_in_stall),
      .divisor   (prof.per_lo),
      .out_valid (mod_out_valid),
      .out_time  (mod_out_time),
      .out_rem   (mod_out_rem),
      .out_stall (eval_in_stall)
   );

   rtp_eval #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_eval (
      .clock         (clock),
      .reset         (reset),
      .prof          (prof),
      .origin_x      (origin_x_ff),
      .origin_y      (origin_y_ff),
      .origin_z      (origin_z_ff),
      .move_axis     (axis_ff),
      .in_valid      (mod_out_valid),
      .in_time       (mod_out_time),
      .in_rem        (mod_out_rem),
      .in_stall      (eval_in_stall),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_pos_x     (rsp_pos_x),
      .rsp_pos_y     (rsp_pos_y),
      .rsp_pos_z     (rsp_pos_z),
      .rsp_vel_x     (rsp_vel_x),
      .rsp_vel_y     (rsp_vel_y),
      .rsp_vel_z     (rsp_vel_z),
      .rsp_returning (rsp_returning)
   );

   // no word enters while the profile constants are stale
   a_no_accept_in_setup : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> !setup_busy)
      else $error("word accepted during profile setup");

   // a csr write always starts a setup pass
   a_write_restarts : assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> (setup_busy && req_stall))
      else $error("csr write did not restart setup");

   // velocity only ever on one axis
   a_one_axis_moves : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($countones({|rsp_vel_x, |rsp_vel_y, |rsp_vel_z}) <= 1))
      else $error("velocity on more than one axis");

endmodule

/* verif/tb.sv */
// Self-checking bench for reciprocating_trapezoid_profile: time samples go in,
// predicted position/velocity words are compared with rsp_ words in order.
// Depends on rtp_pkg and the RTL top level only.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [rtp_pkg::CSR_AW-1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_time_now = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic [31:0] rsp_vel_x, rsp_vel_y, rsp_vel_z;
   logic        rsp_returning;

   reciprocating_trapezoid_profile #(.DATA_WIDTH(32)) uut (.*);

   // clock: 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   typedef struct {
      logic [31:0] px, py, pz, vx, vy, vz;
      logic        ret;
   } motion_word_type;

   // shadow copy of the profile registers
   logic signed [31:0] sh_org [3];
   logic [1:0]  sh_axis;
   logic [30:0] sh_stroke, sh_cruise, sh_accel;

   logic [31:0]     sample_queue [$];
   motion_word_type motion_queue [$];
   int errors = 0;
   int n_checked = 0;
   int n_returning = 0;
   bit hold_req = 0;
   bit hold_seen = 0;
   int hold_cnt = 0;
   int stall_run = 0;

   function automatic logic [63:0] int_sqrt(input logic [63:0] x);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Evaluate the back-and-forth profile at one time stamp.
   function automatic motion_word_type profile_at(input logic [31:0] t_in);
      logic [63:0] len, spd, acc, vmax, ta, tc, da, dc, half, period, tm;
      logic [63:0] vv, dt, s, sc;
      longint p, v, hi, lo;
      longint pos [3];
      longint vel [3];
      bit ret;
      motion_word_type w;
      len = sh_stroke;
      spd = (sh_cruise == 0) ? 64'd1 : 64'(sh_cruise);
      acc = (sh_accel == 0) ? 64'd1 : 64'(sh_accel);
      ret = 0;
      if (spd * spd > acc * len) begin
         // cruise speed never reached: triangular move
         vmax = int_sqrt(acc * len);
         da = len >> 1;
         dc = 0;
         tc = 0;
      end else begin
         vmax = spd;
         da = (spd * spd) / (2 * acc);
         dc = len - 2 * da;
         tc = (dc << 16) / vmax;
      end
      ta = (vmax << 16) / acc;
      half = 2 * ta + tc;
      period = 2 * half;
      if (period == 0) begin
         tm = 0;
      end else begin
         tm = 64'(t_in) % period;
         if (tm >= half) begin
            ret = 1;
            tm = tm - half;
         end
      end
      if (tm < ta) begin
         vv = (acc * tm) >> 16;
         v = longint'(vv);
         p = longint'((vv * tm) >> 17);
      end else if (tm < ta + tc) begin
         dt = tm - ta;
         v = longint'(vmax);
         p = longint'(da + ((vmax * dt) >> 16));
      end else begin
         dt = tm - ta - tc;
         s = (acc * dt) >> 16;
         sc = (s < vmax) ? s : vmax;
         v = longint'(vmax - sc);
         p = longint'(da + dc + ((vmax * dt) >> 16)) - longint'((sc * dt) >> 17);
         if (p > longint'(len)) p = longint'(len);
      end
      if (ret) begin
         p = longint'(len) - p;
         v = -v;
      end
      for (int k = 0; k < 3; k++) begin
         pos[k] = sh_org[k];
         vel[k] = 0;
      end
      if (sh_axis != 2'd3) begin
         hi = 64'sd2147483647;
         lo = -hi - 1;
         pos[sh_axis] = pos[sh_axis] + p;
         if (pos[sh_axis] > hi) pos[sh_axis] = hi;
         if (pos[sh_axis] < lo) pos[sh_axis] = lo;
         vel[sh_axis] = v;
      end
      w.px = pos[0][31:0]; w.py = pos[1][31:0]; w.pz = pos[2][31:0];
      w.vx = vel[0][31:0]; w.vy = vel[1][31:0]; w.vz = vel[2][31:0];
      w.ret = ret;
      return w;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      errors++;
      $display("mismatch %s: got %h expected %h", what, got, want);
   endtask

   // sender: idle gaps of random length, mostly short
   int gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_stall) begin
         motion_queue.push_back(profile_at(req_time_now));
         void'(sample_queue.pop_front());
         gap = ($urandom_range(0, 3) == 0) ? (($urandom_range(0, 19) == 0) ?
               $urandom_range(5, 30) : $urandom_range(1, 3)) : 0;
         if (gap == 0 && sample_queue.size() > 0) begin
            req_time_now <= sample_queue[0];
         end else begin
            req_valid <= 1'b0;
         end
      end else if (!req_valid) begin
         if (gap > 0) gap--;
         else if (sample_queue.size() > 0) begin
            req_valid <= 1'b1;
            req_time_now <= sample_queue[0];
         end
      end
   end

   // receiver: stall runs of random length, plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_req && !hold_seen && rsp_valid) begin
         hold_seen = 1'b1;
         hold_cnt = 300;
         rsp_stall <= 1'b1;
      end else if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_stall <= 1'b1;
      end else if (stall_run > 0) begin
         stall_run--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_run = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 30) :
                     $urandom_range(0, 2);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor: compare every accepted word with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (motion_queue.size() == 0) begin
            report_mismatch("unexpected word", rsp_pos_x, 32'd0);
         end else begin
            motion_word_type w;
            w = motion_queue.pop_front();
            n_checked++;
            if (w.ret) n_returning++;
            if (rsp_pos_x !== w.px) report_mismatch("pos_x", rsp_pos_x, w.px);
            if (rsp_pos_y !== w.py) report_mismatch("pos_y", rsp_pos_y, w.py);
            if (rsp_pos_z !== w.pz) report_mismatch("pos_z", rsp_pos_z, w.pz);
            if (rsp_vel_x !== w.vx) report_mismatch("vel_x", rsp_vel_x, w.vx);
            if (rsp_vel_y !== w.vy) report_mismatch("vel_y", rsp_vel_y, w.vy);
            if (rsp_vel_z !== w.vz) report_mismatch("vel_z", rsp_vel_z, w.vz);
            if (rsp_returning !== w.ret)
               report_mismatch("returning", 32'(rsp_returning), 32'(w.ret));
         end
      end
   end

   // Register write while the pipe is empty; shadow copy follows.
   task automatic write_reg(input logic [rtp_pkg::CSR_AW-1:0] idx,
                            input logic [31:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         rtp_pkg::REG_ORIGIN_X: sh_org[0] = val;
         rtp_pkg::REG_ORIGIN_Y: sh_org[1] = val;
         rtp_pkg::REG_ORIGIN_Z: sh_org[2] = val;
         rtp_pkg::REG_AXIS:     sh_axis = val[1:0];
         rtp_pkg::REG_STROKE:   sh_stroke = val[30:0];
         rtp_pkg::REG_CRUISE:   sh_cruise = val[30:0];
         rtp_pkg::REG_ACCEL:    sh_accel = val[30:0];
         default: ;
      endcase
   endtask

   task automatic drain;
      while (sample_queue.size() > 0 || req_valid || motion_queue.size() > 0)
         @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   // Random time stamp, biased toward the first few round trips.
   function automatic logic [31:0] pick_time(input logic [31:0] span);
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return 32'($urandom_range(0, 64));
         default: return (span == 0) ? $urandom() : $urandom_range(0, span);
      endcase
   endfunction

   logic [30:0] stroke_set [8] = '{31'd6554, 31'd1, 31'h7fffffff, 31'd65536,
                                   31'd0, 31'd200000, 31'd3, 31'd1000};
   logic [30:0] speed_set [8] = '{31'd6554, 31'd1, 31'h7fffffff, 31'd131072,
                                  31'd0, 31'd30000, 31'd70000, 31'd5};
   logic [30:0] accel_set [8] = '{31'd65536, 31'h7fffffff, 31'd1, 31'd262144,
                                  31'd0, 31'd5000, 31'd40000000, 31'd100};

   initial begin
      logic [31:0] span;
      sh_org = '{0, 0, 0};
      sh_axis = rtp_pkg::AXIS_X;
      sh_stroke = rtp_pkg::STROKE_RST;
      sh_cruise = rtp_pkg::CRUISE_RST;
      sh_accel = rtp_pkg::ACCEL_RST;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: reset profile, time extremes and the first trip
      sample_queue.push_back(32'd0);
      sample_queue.push_back(32'hffffffff);
      sample_queue.push_back(32'h80000000);
      sample_queue.push_back(32'h7fffffff);
      for (int k = 0; k < 12; k++) sample_queue.push_back(32'(k * 15000));
      drain();
      // degenerate period with zero stroke, then axis three, then saturation
      write_reg(rtp_pkg::REG_STROKE, 32'd0);
      sample_queue.push_back(32'd12345);
      drain();
      write_reg(rtp_pkg::REG_STROKE, 32'd65536);
      write_reg(rtp_pkg::REG_AXIS, 32'd3);
      sample_queue.push_back(32'd70000);
      sample_queue.push_back(32'd300000);
      drain();
      write_reg(rtp_pkg::REG_AXIS, 32'(rtp_pkg::AXIS_Z));
      write_reg(rtp_pkg::REG_ORIGIN_Z, 32'h7fff0000);
      sample_queue.push_back(32'd65536);
      sample_queue.push_back(32'd131072);
      drain();

      // random phases over several settings, extremes first
      for (int ph = 0; ph < 24; ph++) begin
         write_reg(rtp_pkg::REG_ORIGIN_X, (ph == 1) ? 32'h80000000 : (ph == 2) ?
                   32'h7fffffff : $urandom());
         write_reg(rtp_pkg::REG_ORIGIN_Y, (ph == 1) ? 32'h7fffffff : $urandom());
         write_reg(rtp_pkg::REG_ORIGIN_Z, (ph == 2) ? 32'h80000000 : $urandom());
         write_reg(rtp_pkg::REG_AXIS, 32'(ph % 4));
         write_reg(rtp_pkg::REG_STROKE, (ph < 8) ? {1'b0, stroke_set[ph]} : $urandom());
         write_reg(rtp_pkg::REG_CRUISE, (ph < 8) ? {1'b0, speed_set[ph]} :
                   32'($urandom_range(1, 300000)));
         write_reg(rtp_pkg::REG_ACCEL, (ph < 8) ? {1'b0, accel_set[ph]} :
                   ($urandom_range(0, 1) ? $urandom() : 32'($urandom_range(1, 600000))));
         // rough period estimate used only to focus time stamps
         span = (sh_cruise == 0) ? 32'd0 : 32'(((64'(sh_stroke) << 18) /
                (64'(sh_cruise) | 1)) + ((64'(sh_cruise) << 18) / (64'(sh_accel) | 1)));
         // one phase runs against a long receiver hold-off
         if (ph == 5) hold_req = 1'b1;
         for (int k = 0; k < 60; k++) sample_queue.push_back(pick_time(span));
         drain();
      end
      $display("checked %0d words (%0d on the return half) over 24 register settings",
               n_checked, n_returning);
      $display("covered zero stroke, idle axis, saturation and a full-pipe hold-off");
      if (errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   // watchdog
   initial begin
      #2ms;
      $display("timeout");
      $display("RESULT: ERROR");
      $finish;
   end
endmodule
